// ===== src/dpss_pkg.sv =====
// Shared types and constants for the drum pattern step sequencer.
package dpss_pkg;

  localparam int NUM_PATTERNS  = 16;
  localparam int STEPS_PER_BAR = 16;
  localparam int MAX_BARS      = 4;
  localparam int SONG_SLOTS    = 32;
  localparam int STORE_DEPTH   = 64;
  localparam int HIT_MAX       = 64;

  localparam int PAT_W   = $clog2(NUM_PATTERNS);
  localparam int SLOT_W  = $clog2(SONG_SLOTS);
  localparam int SIDX_W  = $clog2(STORE_DEPTH);
  localparam int CNT_W   = SIDX_W + 1;
  localparam int HIDX_W  = $clog2(HIT_MAX);
  localparam int HCNT_W  = HIDX_W + 1;
  localparam int ADDR_W  = PAT_W + SIDX_W;

  localparam logic [23:0] SPS_MIN   = 24'd256;
  localparam logic [23:0] SPS_RESET = 24'd352800;

  typedef enum logic [3:0] {
    OP_ADD_STEP    = 4'd0,
    OP_CLEAR       = 4'd1,
    OP_SET_BARS    = 4'd2,
    OP_SELECT      = 4'd3,
    OP_SET_SLOT    = 4'd4,
    OP_START_PAT   = 4'd5,
    OP_START_SONG  = 4'd6,
    OP_STOP        = 4'd7,
    OP_ADVANCE     = 4'd8
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_RD,
    ST_CMP,
    ST_STEP_END,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan_init;
    logic rd;
    logic cmp;
    logic step_end;
    logic emit_rd;
    logic emit_out;
    logic status_out;
  } cmd_t;

  typedef struct packed {
    logic is_advance;
    logic adv_skip;
    logic cd_le0;
    logic cnt_zero;
    logic scan_last;
    logic n_zero;
    logic emit_last;
  } sts_t;

  function automatic logic [CNT_W-1:0] pat_len(input logic [2:0] bars);
    pat_len = CNT_W'(int'(bars) * STEPS_PER_BAR);
  endfunction

endpackage

// ===== src/dpss_ctrl.sv =====
// Controller state machine of the drum pattern step sequencer.
module dpss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  dpss_pkg::sts_t sts,
  output dpss_pkg::cmd_t cmd
);
  import dpss_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (start) state_nxt = ST_EXEC;
      ST_EXEC:     state_nxt = (sts.is_advance && !sts.adv_skip) ? ST_CHECK : ST_STATUS;
      ST_CHECK: begin
        if (sts.cd_le0) begin
          state_nxt = sts.cnt_zero ? ST_STEP_END : ST_RD;
        end else begin
          state_nxt = sts.n_zero ? ST_STATUS : ST_EMIT_RD;
        end
      end
      ST_RD:       state_nxt = ST_CMP;
      ST_CMP:      state_nxt = sts.scan_last ? ST_STEP_END : ST_RD;
      ST_STEP_END: state_nxt = ST_CHECK;
      ST_EMIT_RD:  state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: state_nxt = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
      ST_STATUS:   state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.accept     = (state_r == ST_IDLE) && start;
    cmd.exec       = (state_r == ST_EXEC);
    cmd.scan_init  = (state_r == ST_CHECK);
    cmd.rd         = (state_r == ST_RD);
    cmd.cmp        = (state_r == ST_CMP);
    cmd.step_end   = (state_r == ST_STEP_END);
    cmd.emit_rd    = (state_r == ST_EMIT_RD);
    cmd.emit_out   = (state_r == ST_EMIT_OUT);
    cmd.status_out = (state_r == ST_STATUS);
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== src/dpss_datapath.sv =====
// Datapath of the drum pattern step sequencer: stores, playback state and result registers.
module dpss_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  dpss_pkg::cmd_t cmd,
  output dpss_pkg::sts_t sts,
  input  logic           cfg_we,
  input  logic [23:0]    cfg_wdata,
  input  logic [3:0]     in_opcode,
  input  logic [2:0]     in_pad,
  input  logic [5:0]     in_step_index,
  input  logic [6:0]     in_velocity,
  input  logic [2:0]     in_bars,
  input  logic [3:0]     in_pattern_number,
  input  logic [4:0]     in_slot,
  input  logic [11:0]    in_sample_count,
  output logic           out_strobe,
  output logic           out_hit,
  output logic [2:0]     out_hit_pad,
  output logic [6:0]     out_hit_velocity,
  output logic           out_last,
  output logic           out_store_full,
  output logic           out_hits_dropped,
  output logic           out_is_playing,
  output logic [3:0]     out_now_pattern,
  output logic [5:0]     out_now_step,
  output logic [2:0]     out_now_bars
);
  import dpss_pkg::*;

  logic [3:0]  op_r;
  logic [2:0]  pad_r;
  logic [5:0]  sidx_r;
  logic [6:0]  vel_r;
  logic [2:0]  bars_r;
  logic [3:0]  pnum_r;
  logic [4:0]  slot_r;
  logic [11:0] samples_r;

  logic [23:0] sps_r;
  logic [CNT_W-1:0] counts_r [NUM_PATTERNS];
  logic [2:0]       pbars_r  [NUM_PATTERNS];
  logic [PAT_W-1:0] song_r   [SONG_SLOTS];
  logic             running_r;
  logic             song_mode_r;
  logic [PAT_W-1:0] ap_r;
  logic [5:0]       step_pos_r;
  logic [CNT_W-1:0] plen_r;
  logic [SLOT_W-1:0] song_pos_r;
  logic signed [31:0] cd_r;

  logic [15:0] store [NUM_PATTERNS*STORE_DEPTH];
  logic [15:0] store_rd_r;
  logic [9:0]  hbuf [HIT_MAX];
  logic [9:0]  hbuf_rd_r;

  logic [CNT_W-1:0]  scan_i_r;
  logic [HCNT_W-1:0] hit_n_r;
  logic [HIDX_W-1:0] emit_k_r;
  logic              dropped_r;
  logic              full_r;

  logic              out_strobe_r, out_hit_r, out_last_r, out_full_r, out_drop_r;
  logic              out_play_r;
  logic [2:0]        out_pad_r, out_bars_r;
  logic [6:0]        out_vel_r;
  logic [3:0]        out_pat_r;
  logic [5:0]        out_step_r;

  logic [CNT_W-1:0]  cnt_cur;
  logic [CNT_W-1:0]  len_cur;
  logic [CNT_W-1:0]  len_m1;
  logic [5:0]        step_clamped;
  logic [2:0]        bars_clamped;
  logic [23:0]       sps_eff;
  logic [CNT_W-1:0]  pos_inc;
  logic [SLOT_W-1:0] song_pos_inc;
  logic [PAT_W-1:0]  song_pat;
  logic              entry_match;

  assign cnt_cur      = counts_r[ap_r];
  assign len_cur      = pat_len(pbars_r[ap_r]);
  assign len_m1       = len_cur - CNT_W'(1);
  assign step_clamped = ({1'b0, sidx_r} > len_m1) ? len_m1[5:0] : sidx_r;
  assign bars_clamped = (bars_r < 3'd1) ? 3'd1 :
                        (bars_r > 3'(MAX_BARS)) ? 3'(MAX_BARS) : bars_r;
  assign sps_eff      = (sps_r < SPS_MIN) ? SPS_MIN : sps_r;
  assign pos_inc      = {1'b0, step_pos_r} + CNT_W'(1);
  assign song_pos_inc = song_pos_r + SLOT_W'(1);
  assign song_pat     = song_r[song_pos_inc];
  assign entry_match  = (store_rd_r[12:7] == step_pos_r);

  assign sts.is_advance = (op_r == OP_ADVANCE);
  assign sts.adv_skip   = !running_r || (plen_r == '0);
  assign sts.cd_le0     = cd_r[31] || (cd_r == 32'sd0);
  assign sts.cnt_zero   = (cnt_cur == '0);
  assign sts.scan_last  = ((scan_i_r + CNT_W'(1)) == cnt_cur);
  assign sts.n_zero     = (hit_n_r == '0);
  assign sts.emit_last  = (({1'b0, emit_k_r} + HCNT_W'(1)) == hit_n_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_opcode;
      pad_r     <= in_pad;
      sidx_r    <= in_step_index;
      vel_r     <= in_velocity;
      bars_r    <= in_bars;
      pnum_r    <= in_pattern_number;
      slot_r    <= in_slot;
      samples_r <= in_sample_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (op_r == OP_ADD_STEP) && !cnt_cur[CNT_W-1]) begin
      store[{ap_r, cnt_cur[SIDX_W-1:0]}] <= {pad_r, step_clamped, vel_r};
    end
    if (cmd.rd) begin
      store_rd_r <= store[{ap_r, scan_i_r[SIDX_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp && entry_match && !hit_n_r[HCNT_W-1]) begin
      hbuf[hit_n_r[HIDX_W-1:0]] <= {store_rd_r[15:13], store_rd_r[6:0]};
    end
    if (cmd.emit_rd) begin
      hbuf_rd_r <= hbuf[emit_k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_r       <= SPS_RESET;
      running_r   <= 1'b0;
      song_mode_r <= 1'b0;
      ap_r        <= '0;
      step_pos_r  <= '0;
      plen_r      <= '0;
      song_pos_r  <= '0;
      cd_r        <= '0;
      scan_i_r    <= '0;
      hit_n_r     <= '0;
      emit_k_r    <= '0;
      dropped_r   <= 1'b0;
      full_r      <= 1'b0;
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        counts_r[p] <= '0;
        pbars_r[p]  <= 3'd2;
      end
      for (int s = 0; s < SONG_SLOTS; s++) begin
        song_r[s] <= PAT_W'(s % 8);
      end
    end else begin
      if (cfg_we) begin
        sps_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        full_r    <= 1'b0;
        hit_n_r   <= '0;
        dropped_r <= 1'b0;
        emit_k_r  <= '0;
        case (op_r)
          OP_ADD_STEP: begin
            if (cnt_cur[CNT_W-1]) begin
              full_r <= 1'b1;
            end else begin
              counts_r[ap_r] <= cnt_cur + CNT_W'(1);
            end
          end
          OP_CLEAR:    counts_r[ap_r] <= '0;
          OP_SET_BARS: pbars_r[ap_r] <= bars_clamped;
          OP_SELECT:   ap_r <= pnum_r;
          OP_SET_SLOT: song_r[slot_r] <= pnum_r;
          OP_START_PAT: begin
            song_mode_r <= 1'b0;
            running_r   <= 1'b1;
            song_pos_r  <= '0;
            step_pos_r  <= '0;
            plen_r      <= len_cur;
            cd_r        <= '0;
          end
          OP_START_SONG: begin
            song_mode_r <= 1'b1;
            running_r   <= 1'b1;
            song_pos_r  <= '0;
            ap_r        <= song_r[0];
            step_pos_r  <= '0;
            plen_r      <= pat_len(pbars_r[song_r[0]]);
            cd_r        <= '0;
          end
          OP_STOP:     running_r <= 1'b0;
          OP_ADVANCE: begin
            if (!sts.adv_skip) begin
              cd_r <= cd_r - $signed({12'd0, samples_r, 8'd0});
            end
          end
          default: ;
        endcase
      end
      if (cmd.scan_init) begin
        scan_i_r <= '0;
      end
      if (cmd.cmp) begin
        scan_i_r <= scan_i_r + CNT_W'(1);
        if (entry_match) begin
          if (hit_n_r[HCNT_W-1]) begin
            dropped_r <= 1'b1;
          end else begin
            hit_n_r <= hit_n_r + HCNT_W'(1);
          end
        end
      end
      if (cmd.step_end) begin
        cd_r <= cd_r + $signed({8'd0, sps_eff});
        if (pos_inc >= plen_r) begin
          step_pos_r <= '0;
          if (song_mode_r) begin
            song_pos_r <= song_pos_inc;
            ap_r       <= song_pat;
            plen_r     <= pat_len(pbars_r[song_pat]);
          end
        end else begin
          step_pos_r <= pos_inc[5:0];
        end
      end
      if (cmd.emit_out) begin
        emit_k_r <= emit_k_r + HIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit_out || cmd.status_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_out || cmd.status_out) begin
      out_hit_r  <= cmd.emit_out;
      out_pad_r  <= cmd.emit_out ? hbuf_rd_r[9:7] : 3'd0;
      out_vel_r  <= cmd.emit_out ? hbuf_rd_r[6:0] : 7'd0;
      out_last_r <= cmd.status_out || sts.emit_last;
      out_full_r <= cmd.status_out && full_r;
      out_drop_r <= dropped_r;
      out_play_r <= running_r;
      out_pat_r  <= ap_r;
      out_step_r <= step_pos_r;
      out_bars_r <= pbars_r[ap_r];
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_hit          = out_hit_r;
  assign out_hit_pad      = out_pad_r;
  assign out_hit_velocity = out_vel_r;
  assign out_last         = out_last_r;
  assign out_store_full   = out_full_r;
  assign out_hits_dropped = out_drop_r;
  assign out_is_playing   = out_play_r;
  assign out_now_pattern  = out_pat_r;
  assign out_now_step     = out_step_r;
  assign out_now_bars     = out_bars_r;

  a_hit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hit_n_r <= HCNT_W'(HIT_MAX))
    else $error("hit count exceeds buffer depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cmp |-> (scan_i_r < cnt_cur))
    else $error("scan index beyond step count");

  a_full_only_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> !(out_full_r && out_hit_r))
    else $error("store full flagged on a hit result");

  a_emit_has_hits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_out |-> !sts.n_zero)
    else $error("emitting with empty hit buffer");

endmodule

// ===== src/drum_pattern_step_sequencer.sv =====
// Top level of the drum pattern step sequencer.
//
//  channel   ports                               handshake
//  request   start, busy, in_*                   taken when start && !busy
//  result    out_strobe, out_*                   one strobe per result, no stall
//  config    cfg_we, cfg_wdata                   written when cfg_we
//
// Edit and transport requests pass the execute and status states to a single result.
// An advance compares each stored entry of the playing pattern for every elapsed
// step, one by one through the single read port of the step store, then ends the step;
// once the countdown is positive it emits each buffered hit, or else a status result.
// Reset is synchronous, active low, and sets playback state and tables, not the stores.
// Results are delivered from an output register; the receiver cannot stall them.
module drum_pattern_step_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_opcode,
  input  logic [2:0]  in_pad,
  input  logic [5:0]  in_step_index,
  input  logic [6:0]  in_velocity,
  input  logic [2:0]  in_bars,
  input  logic [3:0]  in_pattern_number,
  input  logic [4:0]  in_slot,
  input  logic [11:0] in_sample_count,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  output logic        out_strobe,
  output logic        out_hit,
  output logic [2:0]  out_hit_pad,
  output logic [6:0]  out_hit_velocity,
  output logic        out_last,
  output logic        out_store_full,
  output logic        out_hits_dropped,
  output logic        out_is_playing,
  output logic [3:0]  out_now_pattern,
  output logic [5:0]  out_now_step,
  output logic [2:0]  out_now_bars
);
  import dpss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dpss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  dpss_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_opcode         (in_opcode),
    .in_pad            (in_pad),
    .in_step_index     (in_step_index),
    .in_velocity       (in_velocity),
    .in_bars           (in_bars),
    .in_pattern_number (in_pattern_number),
    .in_slot           (in_slot),
    .in_sample_count   (in_sample_count),
    .out_strobe        (out_strobe),
    .out_hit           (out_hit),
    .out_hit_pad       (out_hit_pad),
    .out_hit_velocity  (out_hit_velocity),
    .out_last          (out_last),
    .out_store_full    (out_store_full),
    .out_hits_dropped  (out_hits_dropped),
    .out_is_playing    (out_is_playing),
    .out_now_pattern   (out_now_pattern),
    .out_now_step      (out_now_step),
    .out_now_bars      (out_now_bars)
  );

endmodule

// ===== tb/drum_pattern_step_sequencer_tb.sv =====
// Self-checking testbench for the drum pattern step sequencer, with a scoreboard class.
`timescale 1ns / 100ps

module drum_pattern_step_sequencer_tb;
  import dpss_pkg::*;

  typedef struct {
    logic [3:0]  op;
    logic [2:0]  pad;
    logic [5:0]  sidx;
    logic [6:0]  vel;
    logic [2:0]  bars;
    logic [3:0]  pnum;
    logic [4:0]  slot;
    logic [11:0] samples;
  } request_t;

  typedef struct {
    logic       hit;
    logic [2:0] pad;
    logic [6:0] vel;
    logic       last;
    logic       full;
    logic       dropped;
    logic       playing;
    logic [3:0] pattern;
    logic [5:0] step;
    logic [2:0] bars;
  } trigger_t;

  class sequencer_scoreboard;
    logic [23:0] sps;
    logic [2:0]  entry_pad[NUM_PATTERNS][STORE_DEPTH];
    logic [5:0]  entry_step[NUM_PATTERNS][STORE_DEPTH];
    logic [6:0]  entry_vel[NUM_PATTERNS][STORE_DEPTH];
    int          entry_count[NUM_PATTERNS];
    int          bars_of[NUM_PATTERNS];
    logic [3:0]  song[SONG_SLOTS];
    bit          running, song_mode;
    int          cur_pat, cur_step, cur_len, song_pos;
    longint      countdown;
    trigger_t    awaited[$];
    int          mismatches;

    function new();
      sps = SPS_RESET;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        entry_count[i] = 0;
        bars_of[i] = 2;
      end
      for (int i = 0; i < SONG_SLOTS; i++) song[i] = 4'(i % 8);
      running = 0;
      song_mode = 0;
      cur_pat = 0;
      cur_step = 0;
      cur_len = 0;
      song_pos = 0;
      countdown = 0;
      mismatches = 0;
    endfunction

    function int step_samples();
      return (sps < SPS_MIN) ? int'(SPS_MIN) : int'(sps);
    endfunction

    function trigger_t finish_trigger(trigger_t t, bit dropped);
      t.dropped = dropped;
      t.playing = running;
      t.pattern = 4'(cur_pat);
      t.step = 6'(cur_step);
      t.bars = 3'(bars_of[cur_pat]);
      t.last = 0;
      return t;
    endfunction

    function void note_request(request_t r);
      trigger_t hits[$];
      trigger_t t;
      bit full, dropped;
      int len, b, p;
      full = 0;
      dropped = 0;
      case (r.op)
        OP_ADD_STEP: begin
          len = bars_of[cur_pat] * STEPS_PER_BAR;
          if (entry_count[cur_pat] >= STORE_DEPTH) begin
            full = 1;
          end else begin
            entry_pad[cur_pat][entry_count[cur_pat]] = r.pad;
            entry_step[cur_pat][entry_count[cur_pat]] = (r.sidx > len - 1) ? 6'(len - 1) : r.sidx;
            entry_vel[cur_pat][entry_count[cur_pat]] = r.vel;
            entry_count[cur_pat]++;
          end
        end
        OP_CLEAR: entry_count[cur_pat] = 0;
        OP_SET_BARS: begin
          b = r.bars;
          if (b < 1) b = 1;
          if (b > MAX_BARS) b = MAX_BARS;
          bars_of[cur_pat] = b;
        end
        OP_SELECT: cur_pat = r.pnum;
        OP_SET_SLOT: song[r.slot] = r.pnum;
        OP_START_PAT, OP_START_SONG: begin
          song_mode = (r.op == OP_START_SONG);
          running = 1;
          song_pos = 0;
          if (song_mode) cur_pat = song[0];
          cur_step = 0;
          cur_len = bars_of[cur_pat] * STEPS_PER_BAR;
          countdown = 0;
        end
        OP_STOP: running = 0;
        OP_ADVANCE: begin
          if (running && cur_len != 0) begin
            countdown -= longint'(r.samples) * 256;
            while (countdown <= 0) begin
              p = cur_pat;
              for (int i = 0; i < entry_count[p]; i++) begin
                if (entry_step[p][i] == cur_step) begin
                  if (hits.size() < HIT_MAX) begin
                    t.hit = 1;
                    t.pad = entry_pad[p][i];
                    t.vel = entry_vel[p][i];
                    t.full = 0;
                    hits.insert(hits.size(), t);
                  end else begin
                    dropped = 1;
                  end
                end
              end
              cur_step++;
              if (cur_step >= cur_len) begin
                cur_step = 0;
                if (song_mode) begin
                  song_pos = (song_pos + 1) % SONG_SLOTS;
                  cur_pat = song[song_pos];
                  cur_len = bars_of[cur_pat] * STEPS_PER_BAR;
                end
              end
              countdown += step_samples();
            end
          end
        end
        default: ;
      endcase
      if (hits.size() == 0) begin
        t.hit = 0;
        t.pad = 0;
        t.vel = 0;
        t.full = full;
        hits.insert(hits.size(), t);
      end
      foreach (hits[k]) begin
        hits[k] = finish_trigger(hits[k], dropped);
        if (k == hits.size() - 1) hits[k].last = 1;
        awaited.insert(awaited.size(), hits[k]);
      end
    endfunction

    function bit field_ok(string name, int e, int a);
      if (e == a) return 1;
      if (mismatches < 10) $display("mismatch on %s: expected %0d, got %0d", name, e, a);
      return 0;
    endfunction

    function void check_result(trigger_t got);
      trigger_t e;
      bit ok;
      if (awaited.size() == 0) begin
        if (mismatches < 10) $display("unexpected result at %0t", $time);
        mismatches++;
        return;
      end
      e = awaited.pop_front();
      ok = field_ok("hit", e.hit, got.hit);
      ok &= field_ok("hit_pad", e.pad, got.pad);
      ok &= field_ok("hit_velocity", e.vel, got.vel);
      ok &= field_ok("last", e.last, got.last);
      ok &= field_ok("store_full", e.full, got.full);
      ok &= field_ok("hits_dropped", e.dropped, got.dropped);
      ok &= field_ok("is_playing", e.playing, got.playing);
      ok &= field_ok("now_pattern", e.pattern, got.pattern);
      ok &= field_ok("now_step", e.step, got.step);
      ok &= field_ok("now_bars", e.bars, got.bars);
      if (!ok) mismatches++;
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [3:0]  in_opcode = 0;
  logic [2:0]  in_pad = 0;
  logic [5:0]  in_step_index = 0;
  logic [6:0]  in_velocity = 0;
  logic [2:0]  in_bars = 0;
  logic [3:0]  in_pattern_number = 0;
  logic [4:0]  in_slot = 0;
  logic [11:0] in_sample_count = 0;
  logic        cfg_we = 0;
  logic [23:0] cfg_wdata = 0;
  logic        out_strobe, out_hit, out_last, out_store_full, out_hits_dropped;
  logic        out_is_playing;
  logic [2:0]  out_hit_pad, out_now_bars;
  logic [6:0]  out_hit_velocity;
  logic [3:0]  out_now_pattern;
  logic [5:0]  out_now_step;

  sequencer_scoreboard sb = new();
  int cycles = 0;
  bit quiet = 0;

  drum_pattern_step_sequencer dut (
    .clk, .rst_n, .start, .busy,
    .in_opcode, .in_pad, .in_step_index, .in_velocity, .in_bars,
    .in_pattern_number, .in_slot, .in_sample_count,
    .cfg_we, .cfg_wdata,
    .out_strobe, .out_hit, .out_hit_pad, .out_hit_velocity, .out_last,
    .out_store_full, .out_hits_dropped, .out_is_playing, .out_now_pattern,
    .out_now_step, .out_now_bars
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    trigger_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_n && out_strobe) begin
      got.hit = out_hit;
      got.pad = out_hit_pad;
      got.vel = out_hit_velocity;
      got.last = out_last;
      got.full = out_store_full;
      got.dropped = out_hits_dropped;
      got.playing = out_is_playing;
      got.pattern = out_now_pattern;
      got.step = out_now_step;
      got.bars = out_now_bars;
      sb.check_result(got);
    end
  end

  task automatic pause(input int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_request(input request_t r);
    start <= 1;
    in_opcode <= r.op;
    in_pad <= r.pad;
    in_step_index <= r.sidx;
    in_velocity <= r.vel;
    in_bars <= r.bars;
    in_pattern_number <= r.pnum;
    in_slot <= r.slot;
    in_sample_count <= r.samples;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
    if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 7));
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.awaited.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_sps(input logic [23:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.sps = v;
    @(posedge clk);
  endtask

  task automatic send_op(input logic [3:0] op, input int a = 0, input int b = 0,
                         input int c = 0);
    request_t r;
    r.op = op;
    r.pad = 3'(a);
    r.sidx = 6'(b);
    r.vel = 7'(c);
    r.bars = 3'(a);
    r.pnum = 4'(a);
    r.slot = 5'(b);
    r.samples = 12'(a);
    send_request(r);
  endtask

  function automatic request_t random_request();
    request_t r;
    int w;
    r.op = 4'($urandom);
    r.pad = 3'($urandom);
    r.sidx = 6'($urandom);
    r.vel = 7'($urandom);
    r.bars = 3'($urandom);
    r.pnum = 4'($urandom);
    r.slot = 5'($urandom);
    r.samples = 12'($urandom);
    w = $urandom_range(0, 99);
    if (w < 30) begin
      r.op = OP_ADD_STEP;
      if ($urandom_range(0, 9) < 7) r.sidx = 6'($urandom_range(0, 15));
    end
    else if (w < 33) r.op = OP_CLEAR;
    else if (w < 38) r.op = OP_SET_BARS;
    else if (w < 45) r.op = OP_SELECT;
    else if (w < 50) r.op = OP_SET_SLOT;
    else if (w < 57) r.op = OP_START_PAT;
    else if (w < 62) r.op = OP_START_SONG;
    else if (w < 65) r.op = OP_STOP;
    else if (w < 68) r.op = 4'($urandom_range(9, 15));
    else r.op = OP_ADVANCE;
    if (r.op == OP_ADVANCE && sb.step_samples() < 65536) r.samples = 12'($urandom_range(0, 31));
    return r;
  endfunction

  initial begin
    logic [23:0] sps_choices[5];
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_sps(24'd0);
    send_op(OP_ADVANCE, 4095);
    send_op(4'd9);
    send_op(4'd15);
    send_op(OP_SET_BARS, 0);
    send_op(OP_SET_BARS, 7);
    send_op(OP_ADD_STEP, 7, 63, 127);
    send_op(OP_ADD_STEP, 0, 0, 0);
    send_op(OP_ADD_STEP, 5, 2, 64);
    send_op(OP_SET_BARS, 1);
    send_op(OP_SELECT, 15);
    send_op(OP_ADD_STEP, 3, 1, 99);
    send_op(OP_SET_SLOT, 15, 31);
    send_op(OP_SET_SLOT, 15, 1);
    send_op(OP_SELECT, 0);
    send_op(OP_START_PAT);
    send_op(OP_ADVANCE, 0);
    send_op(OP_ADVANCE, 3);
    send_op(OP_SELECT, 15);
    send_op(OP_ADVANCE, 20);
    send_op(OP_STOP);
    send_op(OP_ADVANCE, 5);
    send_op(OP_START_SONG);
    send_op(OP_ADVANCE, 31);
    write_sps(24'hFFFFFF);
    send_op(OP_START_PAT);
    send_op(OP_ADVANCE, 4095);
    send_op(OP_ADVANCE, 4095);

    // Fill one pattern past its store so both the refusal and the hit overflow show up.
    write_sps(SPS_MIN);
    send_op(OP_SELECT, 2);
    send_op(OP_CLEAR);
    send_op(OP_SET_BARS, 1);
    for (int i = 0; i <= STORE_DEPTH; i++)
      send_op(OP_ADD_STEP, $urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 127));
    send_op(OP_START_PAT);
    send_op(OP_ADVANCE, 17);
    send_op(OP_CLEAR);

    sps_choices = '{24'd352800, 24'hFFFFFF, SPS_MIN, 24'd0, 24'd4000};
    for (int i = 0; i < 32; i++) begin
      if (i % 10 == 9) begin
        sps_choices[4] = 24'($urandom_range(256, 200000));
        write_sps(sps_choices[$urandom_range(0, 4)]);
      end
      quiet = (i >= 26);
      send_request(random_request());
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
